// ===== rtl/core/ffpa_pkg.sv =====
// Shared types and constants for the first-fit page allocator.
// No dependencies; imported by ffpa_ctrl, ffpa_dp and first_fit_page_allocator.
package ffpa_pkg;

    // Built depth of the page map (default for the top-level parameter)
    localparam int MAX_PAGES_DEF = 1024;

    // Fixed field widths
    localparam int COUNT_W = 11;   // page_count, freed_count, pages_in_use
    localparam int PAGE_W  = 10;   // head_page, first_page
    localparam int RUN_W   = 12;   // run word per page, two's complement

    // Run word written into tail pages (-1)
    localparam logic [RUN_W-1:0] RUN_TAIL = '1;

    // Page total after reset
    localparam logic [COUNT_W-1:0] CFG_RESET = 11'd1024;

    // Stream data widths (whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Request kinds carried in tuser
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACHK,
        ST_SCAN,
        ST_MARK,
        ST_FCHK,
        ST_FWAIT,
        ST_FREE,
        ST_RESP
    } t_state;

    typedef enum logic [1:0] {
        RESP_FAIL,
        RESP_ALLOC,
        RESP_FREE
    } t_resp_kind;

    // Controller to datapath
    typedef struct packed {
        logic       load;       // capture request, pointer to the head page
        logic       scan_init;  // reset scan state, pointer to page 0
        logic       scan;       // scan step: read the next page, check the returned word
        logic       wr_step;    // one map write at the pointer, pointer advances
        logic       wr_mark;    // write run words (else write zero)
        logic       rd_en;      // read the map at the pointer
        logic       free_init;  // set the free sweep end from the head word
        logic       resp_load;  // load the result register
        t_resp_kind kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bad_count;  // allocate count is 0 or not below the page total
        logic found;      // scan hit a free run of the requested length
        logic scan_fail;  // scan covered the page total without a hit
        logic wr_last;    // current write is the last of the sweep
        logic head_ok;    // free head index lies inside the map
        logic word_pos;   // head run word is positive
        logic out_free;   // result register can take a new result
    } t_status;

endpackage

// ===== rtl/core/ffpa_ctrl.sv =====
// Request sequencer of the first-fit page allocator.
// Depends on ffpa_pkg (state, command and status types).
module ffpa_ctrl import ffpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,    // request kind
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    t_resp_kind r_kind, n_kind;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_kind  <= RESP_FAIL;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_step = 1'b1;
                if (i_status.wr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_s_tuser == REQ_FREE) ? ST_FCHK : ST_ACHK;
                end
            end
            ST_ACHK: begin
                if (i_status.bad_count) begin
                    n_kind  = RESP_FAIL;
                    n_state = ST_RESP;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.found) begin
                    n_state = ST_MARK;
                end else if (i_status.scan_fail) begin
                    n_kind  = RESP_FAIL;
                    n_state = ST_RESP;
                end
            end
            ST_MARK: begin
                o_cmd.wr_step = 1'b1;
                o_cmd.wr_mark = 1'b1;
                if (i_status.wr_last) begin
                    n_kind  = RESP_ALLOC;
                    n_state = ST_RESP;
                end
            end
            ST_FCHK: begin
                if (i_status.head_ok) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_FWAIT;
                end else begin
                    n_kind  = RESP_FAIL;
                    n_state = ST_RESP;
                end
            end
            ST_FWAIT: begin
                if (i_status.word_pos) begin
                    o_cmd.free_init = 1'b1;
                    n_state         = ST_FREE;
                end else begin
                    n_kind  = RESP_FAIL;
                    n_state = ST_RESP;
                end
            end
            ST_FREE: begin
                o_cmd.wr_step = 1'b1;
                if (i_status.wr_last) begin
                    n_kind  = RESP_FREE;
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ffpa_dp.sv =====
// Datapath of the first-fit page allocator: page map memory, scan and sweep
// counters, configuration and result registers. Depends on ffpa_pkg.
module ffpa_dp import ffpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request fields
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // configuration
    input  logic                 i_cfg_valid,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    // result stream
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tuser,
    // control
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int TW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
    localparam int EW = ((CW > RUN_W) ? CW : RUN_W) + 1;

    // Page map: run word per page, nonzero means used
    logic [RUN_W-1:0] mem [MAX_PAGES];
    logic [RUN_W-1:0] r_rd_data;

    logic [COUNT_W-1:0] r_cfg_pages;
    logic [COUNT_W-1:0] r_req_count;
    logic [PAGE_W-1:0]  r_req_head;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_end;
    logic [CW-1:0]      r_run;
    logic [CW-1:0]      r_start;
    logic               r_chk;
    logic [CW-1:0]      r_chk_page;

    logic               r_o_valid;
    logic               r_o_success;
    logic [PAGE_W-1:0]  r_o_first;
    logic [COUNT_W-1:0] r_o_freed;

    logic [TW-1:0]      w_total;
    logic [TW-1:0]      w_cfg_ext;
    logic [TW-1:0]      w_ptr_ext;
    logic               w_issue;
    logic               w_used;
    logic               w_found;
    logic [EW-1:0]      w_free_end;
    logic [EW-1:0]      w_max_ext;
    logic               w_wr_en;
    logic [RUN_W-1:0]   w_wr_data;
    logic               w_rd_en;

    // Page total: configured count capped at the built depth
    assign w_cfg_ext = TW'(r_cfg_pages);
    assign w_total   = (w_cfg_ext > TW'(MAX_PAGES)) ? TW'(MAX_PAGES) : w_cfg_ext;
    assign w_ptr_ext = TW'(r_ptr);

    // Scan decisions on the word that just came back
    assign w_issue = i_cmd.scan && (w_ptr_ext < w_total);
    assign w_used  = (r_rd_data != '0);
    assign w_found = r_chk && !w_used && (TW'(r_run) + TW'(1) == TW'(r_req_count));

    // Free sweep end, clipped at the map end
    assign w_max_ext  = EW'(MAX_PAGES);
    assign w_free_end = ((EW'(r_ptr) + EW'(r_rd_data)) > w_max_ext) ? w_max_ext
                      : (EW'(r_ptr) + EW'(r_rd_data));

    // Memory port selection
    assign w_wr_en   = i_cmd.wr_step;
    assign w_wr_data = !i_cmd.wr_mark ? '0
                     : ((r_ptr == r_start) ? RUN_W'(r_req_count) : RUN_TAIL);
    assign w_rd_en   = w_issue || i_cmd.rd_en;

    // Status to the controller
    always_comb begin
        o_status.bad_count = (r_req_count == '0) || (TW'(r_req_count) >= w_total);
        o_status.found     = i_cmd.scan && w_found;
        o_status.scan_fail = !r_chk && (w_ptr_ext >= w_total);
        o_status.wr_last   = ((CW + 1)'(r_ptr) + (CW + 1)'(1)) == (CW + 1)'(r_end);
        o_status.head_ok   = TW'(r_req_head) < TW'(MAX_PAGES);
        o_status.word_pos  = (r_rd_data != '0) && !r_rd_data[RUN_W-1];
        o_status.out_free  = !r_o_valid || i_m_tready;
    end

    // Map memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_ptr[AW-1:0]] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_ptr[AW-1:0]];
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pages <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_pages <= i_cfg_data;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_count <= i_s_tdata[COUNT_W-1:0];
            r_req_head  <= i_s_tdata[COUNT_W +: PAGE_W];
        end
    end

    // Pointer, sweep end and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_end <= CW'(MAX_PAGES);
            r_chk <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                // free sweeps start at the head page
                r_ptr <= CW'(i_s_tdata[COUNT_W +: PAGE_W]);
            end
            if (i_cmd.scan_init) begin
                // allocate scans start at page 0
                r_ptr   <= '0;
                r_run   <= '0;
                r_start <= '0;
                r_chk   <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (w_found) begin
                    // run found: mark pass goes from its head
                    r_ptr <= r_start;
                    r_end <= CW'(TW'(r_start) + TW'(r_req_count));
                    r_chk <= 1'b0;
                end else begin
                    if (r_chk) begin
                        if (w_used) begin
                            r_run   <= '0;
                            r_start <= r_chk_page + CW'(1);
                        end else begin
                            r_run <= r_run + CW'(1);
                        end
                    end
                    r_chk      <= w_issue;
                    r_chk_page <= r_ptr;
                    if (w_issue) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                end
            end
            if (i_cmd.free_init) begin
                r_end <= CW'(w_free_end);
            end
            if (i_cmd.wr_step) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.resp_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            case (i_cmd.kind)
                RESP_ALLOC: begin
                    r_o_success <= 1'b1;
                    r_o_first   <= PAGE_W'(r_start);
                    r_o_freed   <= '0;
                end
                RESP_FREE: begin
                    r_o_success <= 1'b1;
                    r_o_first   <= '0;
                    r_o_freed   <= r_rd_data[COUNT_W-1:0];
                end
                default: begin
                    r_o_success <= 1'b0;
                    r_o_first   <= '0;
                    r_o_freed   <= '0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_success;
    assign o_m_tdata  = M_TDATA_W'({r_o_freed, r_o_first});

endmodule

// ===== rtl/core/first_fit_page_allocator.sv =====
// First-fit contiguous page allocator, top level.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_dp.
//
// Keeps a map of MAX_PAGES pages in one block memory (one 12-bit run word per
// page; nonzero means used) and serves one request at a time. After reset the
// map is cleared by a sweep over all MAX_PAGES pages, during which no request is
// taken; configuration writes are accepted at any time but should only be
// issued while idle. An allocate scans from page 0 to the end of the first
// fitting run (at most the page total) and then marks the run's pages; the
// scan reads one page per cycle through the memory read port, and marking
// writes one page per cycle. A free makes one write per released page.
// Requests that fail their checks answer without writing the map. The result
// waits in an output register until taken.
module first_fit_page_allocator import ffpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [10:0] page_count, [20:11] head_page
    input  logic                 s_tuser,   // [0] req_type
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] first_page, [20:10] freed_count
    output logic                 m_tuser,   // [0] success
    // configuration: pages_in_use
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [COUNT_W-1:0]   i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    ffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tuser  (s_tuser),
        .o_s_tready (s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ffpa_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

// ===== tb/first_fit_page_allocator_tb.sv =====
// Self-checking testbench for first_fit_page_allocator: directed and random
// allocate/free requests checked against a page-map predictor.
// Depends on ffpa_pkg and the first_fit_page_allocator RTL.
`timescale 1ns / 100ps

module first_fit_page_allocator_tb;
    import ffpa_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int LIMIT       = 3_000_000;
    localparam int HOLD_CYCLES = 4000;
    localparam int TAIL_WAIT   = 200;

    typedef enum {JOB_ITEM, JOB_CFG, JOB_DRAIN, JOB_HOLD, JOB_QUIET} t_job_kind;
    typedef enum {PICK_FIXED, PICK_LIVE, PICK_TAIL} t_head_pick;

    typedef struct {
        t_job_kind          kind;
        logic               req_type;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0]  head;
        t_head_pick         pick;
        logic [COUNT_W-1:0] cfg_value;
    } t_page_job;

    typedef struct packed {
        logic               req_type;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0]  head;
    } t_page_req;

    typedef struct packed {
        logic               success;
        logic [PAGE_W-1:0]  first_page;
        logic [COUNT_W-1:0] freed_count;
    } t_page_resp;

    // DUT connections
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data  = '0;

    // predictor copy of the page map and the page total register
    bit                   page_used [MAX_PAGES_DEF];
    bit [RUN_W-1:0]       run_word  [MAX_PAGES_DEF];
    logic [COUNT_W-1:0]   cfg_pages = CFG_RESET;

    t_page_job  request_plan[$];
    t_page_resp predicted_replies[$];
    t_page_req  cur_req;
    logic [COUNT_W-1:0] cfg_value_q = '0;

    int  requests_sent = 0;
    int  replies_seen  = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  errors        = 0;
    int  send_gap      = 0;
    int  cycle_count   = 0;
    bit  quiet_phase   = 1'b0;

    first_fit_page_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // First-fit allocate or free on the predictor map; returns the reply
    function automatic t_page_resp allocate_or_free(t_page_req req);
        t_page_resp     resp;
        int             total, run, start, p, stop;
        bit             found;
        bit [RUN_W-1:0] word;
        resp = '0;
        if (req.req_type == REQ_ALLOC) begin
            total = (cfg_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(cfg_pages);
            if (req.count != 0 && int'(req.count) < total) begin
                run   = 0;
                start = 0;
                found = 1'b0;
                for (p = 0; p < total && !found; p++) begin
                    if (page_used[p]) begin
                        run   = 0;
                        start = p + 1;
                    end else begin
                        run++;
                        found = (run == int'(req.count));
                    end
                end
                if (found) begin
                    for (p = start; p < start + int'(req.count); p++) begin
                        page_used[p] = 1'b1;
                        run_word[p]  = RUN_TAIL;
                    end
                    run_word[start]  = RUN_W'(req.count);
                    resp.success     = 1'b1;
                    resp.first_page  = PAGE_W'(start);
                end
            end
        end else begin
            word = run_word[req.head];
            // only a positive run word marks a run head
            if (word != 0 && !word[RUN_W-1]) begin
                stop = int'(req.head) + int'(word);
                if (stop > MAX_PAGES_DEF) stop = MAX_PAGES_DEF;
                for (p = int'(req.head); p < stop; p++) begin
                    page_used[p] = 1'b0;
                    run_word[p]  = '0;
                end
                resp.success     = 1'b1;
                resp.freed_count = COUNT_W'(word);
            end
        end
        return resp;
    endfunction

    // Choose a live run head or a tail page from the current map
    function automatic logic [PAGE_W-1:0] choose_head(t_head_pick pick,
                                                      logic [PAGE_W-1:0] fallback);
        int cands[$];
        int p;
        if (pick == PICK_FIXED) return fallback;
        for (p = 0; p < MAX_PAGES_DEF; p++) begin
            if (pick == PICK_LIVE && run_word[p] != 0 && !run_word[p][RUN_W-1])
                cands.push_back(p);
            if (pick == PICK_TAIL && run_word[p] == RUN_TAIL)
                cands.push_back(p);
        end
        if (cands.size() == 0) return fallback;
        return PAGE_W'(cands[$urandom_range(0, cands.size() - 1)]);
    endfunction

    task automatic add_item(logic req_type, logic [COUNT_W-1:0] count,
                            logic [PAGE_W-1:0] head, t_head_pick pick);
        t_page_job job;
        job.kind      = JOB_ITEM;
        job.req_type  = req_type;
        job.count     = count;
        job.head      = head;
        job.pick      = pick;
        job.cfg_value = '0;
        request_plan.push_back(job);
    endtask

    task automatic add_job(t_job_kind kind, logic [COUNT_W-1:0] value);
        t_page_job job;
        job.kind      = kind;
        job.req_type  = REQ_ALLOC;
        job.count     = '0;
        job.head      = '0;
        job.pick      = PICK_FIXED;
        job.cfg_value = value;
        request_plan.push_back(job);
    endtask

    // Mostly well-formed allocate/free traffic, some noise
    task automatic add_random(int n);
        int i, r, r2;
        logic [COUNT_W-1:0] cnt;
        for (i = 0; i < n; i++) begin
            r   = $urandom_range(0, 99);
            r2  = $urandom_range(0, 99);
            cnt = COUNT_W'($urandom_range(0, 2047));
            if (r < 55) begin
                if (r2 < 80)      cnt = COUNT_W'($urandom_range(1, 16));
                else if (r2 < 95) cnt = COUNT_W'($urandom_range(17, 64));
                else              cnt = COUNT_W'($urandom_range(1, 1023));
                add_item(REQ_ALLOC, cnt, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
            end else if (r < 85) begin
                add_item(REQ_FREE, cnt, PAGE_W'($urandom_range(0, 1023)), PICK_LIVE);
            end else if (r < 90) begin
                add_item(REQ_FREE, cnt, PAGE_W'($urandom_range(0, 1023)), PICK_TAIL);
            end else if (r < 95) begin
                add_item(REQ_FREE, cnt, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
            end else begin
                add_item(REQ_ALLOC, cnt, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
            end
        end
    endtask

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // request and config driver
    always @(posedge i_clk) begin : request_driver
        t_page_job job;
        bit        item_live, cfg_live, drained;
        if (i_rst_n) begin
            item_live = s_tvalid;
            cfg_live  = i_cfg_valid;
            if (s_tvalid && s_tready) begin
                predicted_replies.push_back(allocate_or_free(cur_req));
                requests_sent++;
                item_live = 1'b0;
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_pages = i_cfg_data;
                cfg_live  = 1'b0;
            end
            drained = (requests_sent == replies_seen) && !item_live;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!item_live && !cfg_live && request_plan.size() > 0) begin
                job = request_plan[0];
                case (job.kind)
                    JOB_ITEM: begin
                        cur_req.req_type = job.req_type;
                        cur_req.count    = job.count;
                        cur_req.head     = choose_head(job.pick, job.head);
                        item_live        = 1'b1;
                        void'(request_plan.pop_front());
                    end
                    JOB_CFG: begin
                        if (drained) begin
                            cfg_value_q = job.cfg_value;
                            cfg_live    = 1'b1;
                            void'(request_plan.pop_front());
                        end
                    end
                    JOB_DRAIN: begin
                        if (drained) void'(request_plan.pop_front());
                    end
                    JOB_HOLD: begin
                        hold_requests <= hold_requests + 1;
                        void'(request_plan.pop_front());
                    end
                    JOB_QUIET: begin
                        quiet_phase <= 1'b1;
                        void'(request_plan.pop_front());
                    end
                    default: ;
                endcase
            end
            s_tvalid    <= item_live;
            s_tdata     <= S_TDATA_W'({cur_req.head, cur_req.count});
            s_tuser     <= cur_req.req_type;
            i_cfg_valid <= cfg_live;
            i_cfg_data  <= cfg_value_q;
        end
    end

    // reply monitor and receiver stalls
    always @(posedge i_clk) begin : reply_monitor
        t_page_resp want, got;
        bit         ready_now;
        int         stall_left, hold_left;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.success     = m_tuser;
                got.first_page  = m_tdata[PAGE_W-1:0];
                got.freed_count = m_tdata[PAGE_W+COUNT_W-1:PAGE_W];
                replies_seen   <= replies_seen + 1;
                if (predicted_replies.size() == 0) begin
                    $display("%0t: unexpected reply success=%0b first_page=%0d freed_count=%0d",
                             $time, got.success, got.first_page, got.freed_count);
                    errors++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.success !== want.success || got.first_page !== want.first_page ||
                        got.freed_count !== want.freed_count) begin
                        $display("%0t: reply mismatch expected %0b/%0d/%0d actual %0b/%0d/%0d",
                                 $time, want.success, want.first_page, want.freed_count,
                                 got.success, got.first_page, got.freed_count);
                        errors++;
                    end
                end
            end
            // long hold-off first, then random stall bursts
            if (hold_left > 0) begin
                hold_left--;
                ready_now = 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES - 1;
                ready_now   = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_now = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                ready_now  = 1'b0;
            end else begin
                ready_now = 1'b1;
            end
            m_tready <= ready_now;
        end
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus plan and end of run
    initial begin
        // bad counts, full map, run ending at the last page
        add_item(REQ_ALLOC, 11'd0,    PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd1024, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd2047, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd1023, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd1,    PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd1,    PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        // free at a tail page, at the last page, at a free page
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd512,  PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd1023, PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd1023, PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd0,    PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd0,    PICK_FIXED);
        // holes in the map
        add_item(REQ_ALLOC, 11'd5, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd1, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd0, PICK_FIXED);
        add_item(REQ_ALLOC, 11'd3, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_ALLOC, 11'd3, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        // page total of zero, one, above depth, two
        add_job(JOB_CFG, 11'd0);
        add_item(REQ_ALLOC, 11'd1, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_job(JOB_CFG, 11'd1);
        add_item(REQ_ALLOC, 11'd1, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd5, PICK_FIXED);
        add_job(JOB_CFG, 11'd2047);
        add_item(REQ_ALLOC, 11'd1, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_job(JOB_CFG, 11'd2);
        add_item(REQ_ALLOC, 11'd1, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);
        add_item(REQ_FREE, COUNT_W'($urandom_range(0, 2047)), 10'd0, PICK_FIXED);
        add_item(REQ_ALLOC, 11'd1, PAGE_W'($urandom_range(0, 1023)), PICK_FIXED);

        // random phases over several page totals
        add_job(JOB_CFG, 11'd1024);
        add_random(60);
        add_job(JOB_HOLD, '0);
        add_random(8);
        add_random(40);
        add_job(JOB_DRAIN, '0);
        add_random(30);
        add_job(JOB_CFG, 11'd48);
        add_random(40);
        add_job(JOB_CFG, COUNT_W'($urandom_range(1, 1023)));
        add_random(30);
        add_job(JOB_CFG, 11'd1500);
        add_random(20);
        add_job(JOB_CFG, 11'd1024);
        add_job(JOB_QUIET, '0);
        add_random(35);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so driver updates have settled
        while (request_plan.size() != 0 || s_tvalid || i_cfg_valid ||
               predicted_replies.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_ctrl.sv
rtl/core/ffpa_dp.sv
rtl/core/first_fit_page_allocator.sv
tb/first_fit_page_allocator_tb.sv
